FILE: rtl/hciuh4_pkg.sv
// ----------------------------------------------------------------------------
// HCI UART H4 deframer package
// Shared types, codes and helpers for the H4 byte stream deframer.
// ----------------------------------------------------------------------------
package hciuh4_pkg;

   localparam logic [16:0] MAX_PACKET_BYTES = 17'd4096;

   localparam logic [2:0] KIND_CMD     = 3'd0;
   localparam logic [2:0] KIND_ACL     = 3'd1;
   localparam logic [2:0] KIND_SCO     = 3'd2;
   localparam logic [2:0] KIND_EVENT   = 3'd3;
   localparam logic [2:0] KIND_ISO     = 3'd4;
   localparam logic [2:0] KIND_UNKNOWN = 3'd5;

   localparam logic [7:0] IND_FIRST = 8'h01;
   localparam logic [7:0] IND_LAST  = 8'h05;

   localparam logic [15:0] ISO_LEN_MASK = 16'h3FFF;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNKNOWN  = 2'd1;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd2;

   localparam logic [1:0] CSR_SINK_READY     = 2'd0;
   localparam logic [1:0] CSR_TRIGGER_OPCODE = 2'd1;
   localparam logic [1:0] CSR_LOG_FROM_START = 2'd2;

   localparam logic [15:0] TRIGGER_OPCODE_RESET = 16'hFC16;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_HEADER   = 2'd1,
      PH_PAYLOAD  = 2'd2,
      PH_OVERSIZE = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  kind;
      logic [1:0]  hdr_idx;
      logic [15:0] hdr_word;
      logic [15:0] remaining;
   } ctx_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_direction;
      logic       packet_start;
      logic       packet_end;
      logic [2:0] packet_kind;
      logic       log_keep;
      logic [1:0] status;
   } result_type;

   typedef struct packed {
      logic sink_ready;
      logic log_from_start;
      logic logging_on;
   } log_ctrl_type;

   function automatic logic [2:0] hdr_len(input logic [2:0] kind);
      logic [2:0] len;
      unique case (kind)
         KIND_CMD:   len = 3'd3;
         KIND_ACL:   len = 3'd4;
         KIND_SCO:   len = 3'd3;
         KIND_EVENT: len = 3'd2;
         KIND_ISO:   len = 3'd4;
         default:    len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/hciuh4_if.sv
// ----------------------------------------------------------------------------
// HCI UART H4 deframer channels
// Valid/ready channels for stream bytes in and annotated bytes out.
// ----------------------------------------------------------------------------
interface hciuh4_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       direction;

   modport source (output valid, output data_byte, output direction, input ready);
   modport sink   (input valid, input data_byte, input direction, output ready);
endinterface

interface hciuh4_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_direction;
   logic       packet_start;
   logic       packet_end;
   logic [2:0] packet_kind;
   logic       log_keep;
   logic [1:0] status;

   modport source (output valid, output out_byte, output out_direction,
                   output packet_start, output packet_end, output packet_kind,
                   output log_keep, output status, input ready);
   modport sink   (input valid, input out_byte, input out_direction,
                   input packet_start, input packet_end, input packet_kind,
                   input log_keep, input status, output ready);
endinterface

FILE: rtl/hciuh4_step.sv
// ----------------------------------------------------------------------------
// HCI UART H4 deframer parse step
// Advances one direction's packet parser by one byte and classifies it.
// ----------------------------------------------------------------------------
module hciuh4_step
   import hciuh4_pkg::*;
(
   input  ctx_type      ctx,
   input  logic [7:0]   data_byte,
   input  logic         direction,
   input  logic [15:0]  trigger_opcode,
   input  log_ctrl_type log_ctrl,
   output ctx_type      ctx_next,
   output logic         trigger_hit,
   output result_type   result
);

   phase_type   phase;
   logic        is_ind;
   logic [2:0]  ind_kind;
   logic [15:0] hw_upd;
   logic        done;
   logic [15:0] len;
   logic        len_zero;
   logic [16:0] pkt_total;
   logic        over;
   logic [15:0] rem_dec;
   logic        pay_last;
   logic        keep_en;

   // decode shared by next state and outputs
   always_comb begin
      phase = ctx.phase;
      if (ctx.phase != PH_IDLE && ctx.kind > KIND_ISO) begin
         phase = PH_IDLE;
      end
      is_ind   = (data_byte >= IND_FIRST) && (data_byte <= IND_LAST);
      ind_kind = data_byte[2:0] - 3'd1;

      hw_upd = ctx.hdr_word;
      done   = 1'b0;
      len    = 16'd0;
      if (ctx.hdr_idx == 2'd0) begin
         hw_upd = {8'd0, data_byte};
      end else if (ctx.hdr_idx == 2'd1 && ctx.kind != KIND_EVENT) begin
         hw_upd = {data_byte, ctx.hdr_word[7:0]};
      end
      if (ctx.kind == KIND_EVENT) begin
         if (ctx.hdr_idx != 2'd0) begin
            done = 1'b1;
            len  = {8'd0, data_byte};
         end
      end else if (ctx.kind == KIND_CMD || ctx.kind == KIND_SCO) begin
         if (ctx.hdr_idx >= 2'd2) begin
            done = 1'b1;
            len  = {8'd0, data_byte};
         end
      end else begin
         if (ctx.hdr_idx == 2'd2) begin
            hw_upd = {8'd0, data_byte};
         end else if (ctx.hdr_idx == 2'd3) begin
            done = 1'b1;
            len  = {data_byte, ctx.hdr_word[7:0]};
            if (ctx.kind == KIND_ISO) begin
               len = len & ISO_LEN_MASK;
            end
         end
      end
      len_zero  = (len == 16'd0);
      pkt_total = {1'b0, len} + 17'd1 + {14'd0, hdr_len(ctx.kind)};
      over      = pkt_total > MAX_PACKET_BYTES;

      trigger_hit = (phase == PH_HEADER) && (ctx.kind == KIND_CMD)
                    && (ctx.hdr_idx >= 2'd2) && (ctx.hdr_word == trigger_opcode);
      keep_en = (log_ctrl.logging_on | trigger_hit | log_ctrl.log_from_start)
                & log_ctrl.sink_ready;

      rem_dec  = (ctx.remaining != 16'd0) ? ctx.remaining - 16'd1 : 16'd0;
      pay_last = (rem_dec == 16'd0);
   end

   // next state
   always_comb begin
      ctx_next = ctx;
      unique case (phase)
         PH_IDLE: begin
            if (is_ind) begin
               ctx_next.phase     = PH_HEADER;
               ctx_next.kind      = ind_kind;
               ctx_next.hdr_idx   = 2'd0;
               ctx_next.hdr_word  = 16'd0;
               ctx_next.remaining = 16'd0;
            end else begin
               ctx_next.phase = PH_IDLE;
            end
         end
         PH_HEADER: begin
            ctx_next.hdr_idx  = ctx.hdr_idx + 2'd1;
            ctx_next.hdr_word = hw_upd;
            if (done) begin
               if (len_zero) begin
                  ctx_next.phase = PH_IDLE;
               end else begin
                  ctx_next.remaining = len;
                  ctx_next.phase     = over ? PH_OVERSIZE : PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD, PH_OVERSIZE: begin
            ctx_next.remaining = rem_dec;
            if (pay_last) begin
               ctx_next.phase = PH_IDLE;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      result               = '0;
      result.out_byte      = data_byte;
      result.out_direction = direction;
      result.packet_kind   = ctx.kind;
      result.status        = STATUS_OK;
      unique case (phase)
         PH_IDLE: begin
            if (is_ind) begin
               result.packet_start = 1'b1;
               result.packet_kind  = ind_kind;
            end else begin
               result.packet_kind = KIND_UNKNOWN;
               result.status      = STATUS_UNKNOWN;
            end
         end
         PH_HEADER: begin
            if (done && over) begin
               result.status = STATUS_OVERSIZE;
            end
            if (done && len_zero) begin
               result.packet_end = 1'b1;
               result.log_keep   = !over && keep_en;
            end
         end
         PH_PAYLOAD: begin
            result.packet_end = pay_last;
            result.log_keep   = pay_last && keep_en;
         end
         PH_OVERSIZE: begin
            result.status     = STATUS_OVERSIZE;
            result.packet_end = pay_last;
         end
      endcase
   end

endmodule

FILE: rtl/hci_uart_h4_deframer_unit.sv
// ----------------------------------------------------------------------------
// HCI UART H4 deframer
// Splits the send and receive H4 byte streams into HCI packets.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while rsp is not stalled and presents
// exactly one annotated byte for it on rsp through an input register, then
// the result register. Each direction has its own parser context; the shared
// logging flag latches once a command header carries the trigger opcode.
// Sustained rate is one byte per clock and is set only by rsp.ready: a byte
// moves from the input register to the result register whenever the result
// register is empty or being taken, so a new request is accepted in the same
// cycle. Configuration writes take effect at the next edge.
// ----------------------------------------------------------------------------
module hci_uart_h4_deframer_unit
   import hciuh4_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   hciuh4_req_if.sink          req,
   hciuh4_rsp_if.source        rsp,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   logic         sink_ready_ff;
   logic [15:0]  trigger_opcode_ff;
   logic         log_from_start_ff;
   logic         logging_on_ff;

   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_dir_ff;

   ctx_type      ctx_ff [2];
   ctx_type      ctx_in;

   logic         rsp_valid_ff;
   result_type   rsp_data_ff;
   result_type   result;

   logic         advance;
   logic         trigger_hit;
   log_ctrl_type log_ctrl;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   assign log_ctrl.sink_ready     = sink_ready_ff;
   assign log_ctrl.log_from_start = log_from_start_ff;
   assign log_ctrl.logging_on     = logging_on_ff;

   hciuh4_step u_step (
      .ctx            (ctx_ff[in_dir_ff]),
      .data_byte      (in_byte_ff),
      .direction      (in_dir_ff),
      .trigger_opcode (trigger_opcode_ff),
      .log_ctrl       (log_ctrl),
      .ctx_next       (ctx_in),
      .trigger_hit    (trigger_hit),
      .result         (result)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sink_ready_ff     <= 1'b1;
         trigger_opcode_ff <= TRIGGER_OPCODE_RESET;
         log_from_start_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SINK_READY:     sink_ready_ff     <= csr_wdata[0];
            CSR_TRIGGER_OPCODE: trigger_opcode_ff <= csr_wdata;
            CSR_LOG_FROM_START: log_from_start_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.data_byte;
         in_dir_ff  <= req.direction;
      end
   end

   // parser contexts and logging flag
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff[0]     <= '0;
         ctx_ff[1]     <= '0;
         logging_on_ff <= 1'b0;
      end else if (advance) begin
         ctx_ff[in_dir_ff] <= ctx_in;
         if (trigger_hit) begin
            logging_on_ff <= 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_byte      = rsp_data_ff.out_byte;
   assign rsp.out_direction = rsp_data_ff.out_direction;
   assign rsp.packet_start  = rsp_data_ff.packet_start;
   assign rsp.packet_end    = rsp_data_ff.packet_end;
   assign rsp.packet_kind   = rsp_data_ff.packet_kind;
   assign rsp.log_keep      = rsp_data_ff.log_keep;
   assign rsp.status        = rsp_data_ff.status;

endmodule

FILE: rtl/hciuh4_checker.sv
// ----------------------------------------------------------------------------
// HCI UART H4 deframer port checker
// Port-level assertions on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module hciuh4_checker
   import hciuh4_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_packet_start,
   input logic       rsp_packet_end,
   input logic [2:0] rsp_packet_kind,
   input logic       rsp_log_keep,
   input logic [1:0] rsp_status
);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_status))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_start |->
         rsp_status == STATUS_OK && rsp_packet_kind != KIND_UNKNOWN
         && !rsp_log_keep)
      else $error("bad packet start annotation");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_UNKNOWN |->
         rsp_packet_kind == KIND_UNKNOWN && !rsp_packet_start && !rsp_packet_end)
      else $error("bad discarded byte annotation");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_log_keep |-> rsp_packet_end && rsp_status == STATUS_OK)
      else $error("log keep outside a good packet end");

endmodule

bind hci_uart_h4_deframer_unit hciuh4_checker u_hciuh4_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_out_byte     (rsp.out_byte),
   .rsp_packet_start (rsp.packet_start),
   .rsp_packet_end   (rsp.packet_end),
   .rsp_packet_kind  (rsp.packet_kind),
   .rsp_log_keep     (rsp.log_keep),
   .rsp_status       (rsp.status)
);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// HCI UART H4 deframer testbench
// Feeds interleaved send and receive H4 byte streams through the deframer:
// a directed table of indicator, header, masked-length and zero-length cases,
// then random packets with noise, cut-off frames and the odd oversize one
// under several log settings.
// Every response is compared field by field with a typed directed row or a
// per-direction parser model kept in step with each accepted request.
// ----------------------------------------------------------------------------
module testbench;
   import hciuh4_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int N_ROWS      = 24;

   typedef struct packed {
      logic [7:0]  b;
      logic        d;
      logic [15:0] reps;
      logic        typed;
      logic        pstart;
      logic        pend;
      logic [2:0]  kind;
      logic        keep;
      logic [1:0]  st;
   } stim_row_type;

   localparam stim_row_type DIRECTED [N_ROWS] = '{
      '{8'h00, 1'b0, 16'd1,    1'b1, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0, STATUS_UNKNOWN},
      '{8'hFF, 1'b1, 16'd1,    1'b1, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0, STATUS_UNKNOWN},
      '{8'h06, 1'b0, 16'd1,    1'b1, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0, STATUS_UNKNOWN},
      '{8'h04, 1'b1, 16'd1,    1'b1, 1'b1, 1'b0, KIND_EVENT,   1'b0, STATUS_OK},
      '{8'h0E, 1'b1, 16'd1,    1'b1, 1'b0, 1'b0, KIND_EVENT,   1'b0, STATUS_OK},
      '{8'h00, 1'b1, 16'd1,    1'b1, 1'b0, 1'b1, KIND_EVENT,   1'b0, STATUS_OK},
      '{8'h01, 1'b0, 16'd1,    1'b1, 1'b1, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'h03, 1'b0, 16'd1,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'h0C, 1'b0, 16'd1,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'h02, 1'b0, 16'd1,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'hA5, 1'b0, 16'd2,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'h05, 1'b1, 16'd1,    1'b1, 1'b1, 1'b0, KIND_ISO,     1'b0, STATUS_OK},
      '{8'h00, 1'b1, 16'd2,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'h03, 1'b1, 16'd1,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'hC0, 1'b1, 16'd1,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'h7F, 1'b1, 16'd3,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'h02, 1'b0, 16'd1,    1'b1, 1'b1, 1'b0, KIND_ACL,     1'b0, STATUS_OK},
      '{8'h01, 1'b0, 16'd2,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'h03, 1'b0, 16'd1,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'h00, 1'b0, 16'd1,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'h55, 1'b0, 16'd3,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'h05, 1'b1, 16'd1,    1'b1, 1'b1, 1'b0, KIND_ISO,     1'b0, STATUS_OK},
      '{8'h00, 1'b1, 16'd3,    1'b0, 1'b0, 1'b0, KIND_CMD,     1'b0, STATUS_OK},
      '{8'hC0, 1'b1, 16'd1,    1'b1, 1'b0, 1'b1, KIND_ISO,     1'b0, STATUS_OK}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_SINK_READY;
   logic [15:0] csr_wdata = 16'd0;

   hciuh4_req_if req_ch ();
   hciuh4_rsp_if rsp_ch ();

   hci_uart_h4_deframer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser model state, per direction
   phase_type   ctx_phase [2];
   logic [2:0]  ctx_kind [2];
   logic [15:0] ctx_word [2];
   logic [15:0] ctx_left [2];
   logic [2:0]  ctx_idx [2];
   logic        m_ready = 1'b1;
   logic [15:0] m_trig = TRIGGER_OPCODE_RESET;
   logic        m_from_start = 1'b0;
   logic        m_logging = 1'b0;

   result_type  expected_rsp [$];
   logic [7:0]  host_bytes [$];
   logic [7:0]  ctrl_bytes [$];
   logic [7:0]  frame_bytes [$];
   int          err_count = 0;
   int          quiet_cycles = 0;
   int          burst_left = 0;
   int          stall_left = 0;
   logic [3:0]  stall_pos = 4'd0;
   logic [15:0] stall_pat = 16'hFFFF;
   logic        cur_dir = 1'b0;
   logic        arm_trigger = 1'b0;
   result_type  row_rsp;
   result_type  want_rsp;
   result_type  got_rsp;

   function automatic result_type deframe_byte(input logic [7:0] b, input logic d);
      result_type r;
      logic [2:0] k;
      logic [2:0] idx;
      int         len;
      int         hlen;
      logic       done;
      logic       over;
      logic       ends_ok;
      r = '0;
      r.out_byte = b;
      r.out_direction = d;
      k = ctx_kind[d];
      len = 0;
      done = 1'b0;
      over = 1'b0;
      ends_ok = 1'b0;
      case (ctx_phase[d])
         PH_IDLE: begin
            if (b >= IND_FIRST && b <= IND_LAST) begin
               k = 3'(b - IND_FIRST);
               ctx_kind[d] = k;
               ctx_phase[d] = PH_HEADER;
               ctx_word[d] = 16'd0;
               ctx_left[d] = 16'd0;
               ctx_idx[d] = 3'd0;
               r.packet_start = 1'b1;
               r.packet_kind = k;
            end else begin
               r.packet_kind = KIND_UNKNOWN;
               r.status = STATUS_UNKNOWN;
            end
         end
         PH_HEADER: begin
            idx = ctx_idx[d];
            ctx_idx[d] = idx + 3'd1;
            r.packet_kind = k;
            if (idx == 3'd0) ctx_word[d] = {8'h00, b};
            else if (idx == 3'd1 && k != KIND_EVENT) ctx_word[d][15:8] = b;
            case (k)
               KIND_EVENT: begin
                  if (idx >= 3'd1) begin
                     len = int'(b);
                     done = 1'b1;
                  end
               end
               KIND_CMD, KIND_SCO: begin
                  if (idx >= 3'd2) begin
                     if (k == KIND_CMD && ctx_word[d] == m_trig) m_logging = 1'b1;
                     len = int'(b);
                     done = 1'b1;
                  end
               end
               default: begin
                  if (idx == 3'd2) begin
                     ctx_word[d] = {8'h00, b};
                  end else if (idx >= 3'd3) begin
                     len = int'({b, ctx_word[d][7:0]});
                     if (k == KIND_ISO) len = len & int'(ISO_LEN_MASK);
                     done = 1'b1;
                  end
               end
            endcase
            if (done) begin
               case (k)
                  KIND_EVENT:         hlen = 2;
                  KIND_CMD, KIND_SCO: hlen = 3;
                  default:            hlen = 4;
               endcase
               over = (1 + hlen + len) > int'(MAX_PACKET_BYTES);
               if (over) r.status = STATUS_OVERSIZE;
               if (len == 0) begin
                  r.packet_end = 1'b1;
                  ends_ok = !over;
                  ctx_phase[d] = PH_IDLE;
               end else begin
                  ctx_left[d] = 16'(len);
                  ctx_phase[d] = over ? PH_OVERSIZE : PH_PAYLOAD;
               end
            end
         end
         default: begin
            r.packet_kind = k;
            if (ctx_phase[d] == PH_OVERSIZE) r.status = STATUS_OVERSIZE;
            if (ctx_left[d] != 16'd0) ctx_left[d] = ctx_left[d] - 16'd1;
            if (ctx_left[d] == 16'd0) begin
               r.packet_end = 1'b1;
               ends_ok = (ctx_phase[d] == PH_PAYLOAD);
               ctx_phase[d] = PH_IDLE;
            end
         end
      endcase
      r.log_keep = ends_ok & (m_logging | m_from_start) & m_ready;
      return r;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic d, input logic typed,
                            input result_type want);
      result_type model_rsp;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.direction <= d;
      do @(posedge clock); while (!req_ch.ready);
      model_rsp = deframe_byte(b, d);
      expected_rsp.push_back(typed ? want : model_rsp);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SINK_READY:     m_ready = val[0];
         CSR_TRIGGER_OPCODE: m_trig = val;
         CSR_LOG_FROM_START: m_from_start = val[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(input logic dr, input logic [15:0] trig, input logic lfs,
                             input logic arm);
      drain();
      write_reg(CSR_SINK_READY, {15'd0, dr});
      write_reg(CSR_TRIGGER_OPCODE, trig);
      write_reg(CSR_LOG_FROM_START, {15'd0, lfs});
      csr_we <= 1'b0;
      arm_trigger = arm;
   endtask

   task automatic build_packet();
      int          sel;
      int          plen;
      int          cut;
      logic [2:0]  kind;
      logic [15:0] op;
      frame_bytes.delete();
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         frame_bytes.push_back(sel < 2 ? 8'h00 : 8'($urandom_range(6, 255)));
         return;
      end
      kind = 3'($urandom_range(0, 4));
      if ($urandom_range(0, 11) == 0) plen = 0;
      else if ($urandom_range(0, 19) == 0) plen = $urandom_range(0, 255);
      else plen = $urandom_range(1, 24);
      if ((kind == KIND_ACL || kind == KIND_ISO) && $urandom_range(0, 149) == 0)
         plen = $urandom_range(4085, 4100);
      frame_bytes.push_back(8'(kind) + IND_FIRST);
      case (kind)
         KIND_CMD: begin
            op = (arm_trigger && $urandom_range(0, 4) == 0) ? m_trig : 16'($urandom);
            frame_bytes.push_back(op[7:0]);
            frame_bytes.push_back(op[15:8]);
            frame_bytes.push_back(plen[7:0]);
         end
         KIND_ACL: begin
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(plen[7:0]);
            frame_bytes.push_back(plen[15:8]);
         end
         KIND_ISO: begin
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(plen[7:0]);
            frame_bytes.push_back({2'($urandom), plen[13:8]});
         end
         KIND_SCO: begin
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(plen[7:0]);
         end
         default: begin
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(plen[7:0]);
         end
      endcase
      repeat (plen) frame_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 19) == 0) begin
         cut = $urandom_range(1, frame_bytes.size() - 1);
         repeat (cut) void'(frame_bytes.pop_back());
      end
   endtask

   task automatic run_traffic(input int n_items);
      logic [7:0] b;
      repeat (n_items) begin
         if ($urandom_range(0, 3) == 0) cur_dir = ~cur_dir;
         if ((cur_dir ? ctrl_bytes.size() : host_bytes.size()) == 0) begin
            build_packet();
            foreach (frame_bytes[i]) begin
               if (cur_dir) ctrl_bytes.push_back(frame_bytes[i]);
               else host_bytes.push_back(frame_bytes[i]);
            end
         end
         b = cur_dir ? ctrl_bytes.pop_front() : host_bytes.pop_front();
         send_byte(b, cur_dir, 1'b0, '0);
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         err_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'd0;
      req_ch.direction = 1'b0;
      rsp_ch.ready = 1'b0;
      for (int d = 0; d < 2; d++) begin
         ctx_phase[d] = PH_IDLE;
         ctx_kind[d] = KIND_CMD;
         ctx_word[d] = 16'd0;
         ctx_left[d] = 16'd0;
         ctx_idx[d] = 3'd0;
      end
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_ROWS; i++) begin
         row_rsp = '{DIRECTED[i].b, DIRECTED[i].d, DIRECTED[i].pstart, DIRECTED[i].pend,
                     DIRECTED[i].kind, DIRECTED[i].keep, DIRECTED[i].st};
         repeat (DIRECTED[i].reps)
            send_byte(DIRECTED[i].b, DIRECTED[i].d, DIRECTED[i].typed, row_rsp);
      end

      set_config(1'b1, TRIGGER_OPCODE_RESET, 1'b0, 1'b0);
      run_traffic(300);
      set_config(1'b1, 16'h0000, 1'b1, 1'b0);
      run_traffic(300);
      set_config(1'b0, 16'h0000, 1'b1, 1'b0);
      run_traffic(250);
      set_config(1'b1, 16'hFFFF, 1'b0, 1'b1);
      run_traffic(300);
      set_config(1'b0, 16'($urandom), 1'b0, 1'b1);
      run_traffic(250);
      set_config(1'b1, TRIGGER_OPCODE_RESET, 1'b0, 1'b1);
      run_traffic(250);

      drain();
      repeat (8) @(negedge clock);
      if (err_count == 0 && expected_rsp.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                   : (16'($urandom) | (16'h0001 << $urandom_range(0, 15)));
         stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      stall_pos = stall_pos + 4'd1;
      rsp_ch.ready <= stall_pat[stall_pos];
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_rsp = '{rsp_ch.out_byte, rsp_ch.out_direction, rsp_ch.packet_start,
                     rsp_ch.packet_end, rsp_ch.packet_kind, rsp_ch.log_keep, rsp_ch.status};
         if (expected_rsp.size() == 0) begin
            err_count++;
            $display("%0t: response with none expected, expected none, actual %h",
                     $time, got_rsp);
         end else begin
            want_rsp = expected_rsp.pop_front();
            check_field("out_byte", want_rsp.out_byte, got_rsp.out_byte);
            check_field("out_direction", want_rsp.out_direction, got_rsp.out_direction);
            check_field("packet_start", want_rsp.packet_start, got_rsp.packet_start);
            check_field("packet_end", want_rsp.packet_end, got_rsp.packet_end);
            check_field("packet_kind", want_rsp.packet_kind, got_rsp.packet_kind);
            check_field("log_keep", want_rsp.log_keep, got_rsp.log_keep);
            check_field("status", want_rsp.status, got_rsp.status);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

FILE: filelist.f
rtl/hciuh4_pkg.sv
rtl/hciuh4_if.sv
rtl/hciuh4_step.sv
rtl/hci_uart_h4_deframer_unit.sv
rtl/hciuh4_checker.sv
test/testbench.sv
